>>> design/single_button_dimmer_ramp_unit_macros.svh
`ifndef SINGLE_BUTTON_DIMMER_RAMP_UNIT_MACROS_SVH
`define SINGLE_BUTTON_DIMMER_RAMP_UNIT_MACROS_SVH

// Same-cycle implication, ignored while reset is applied.
`define SBD_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sbd assertion failed");

// Next-cycle implication, ignored while reset is applied.
`define SBD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sbd assertion failed");

// Next-cycle implication that is checked during reset as well.
`define SBD_ASSERT_RESET(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("sbd reset assertion failed");

`endif

>>> design/sbd_pkg.sv
package sbd_pkg;

    localparam int unsigned DutyW = 8;
    localparam int unsigned CfgIdxW = 3;

    localparam logic [DutyW-1:0] PULSE_STEP = 8'd5;
    localparam logic [DutyW-1:0] LOW_PEAK   = 8'd75;
    localparam logic [DutyW-1:0] LOW_START  = 8'd5;
    localparam logic [DutyW-1:0] HIGH_FLOOR = 8'd155;
    localparam logic [DutyW-1:0] HIGH_START = 8'd250;
    localparam logic [DutyW-1:0] RAMP_TOP   = 8'd254;
    localparam logic [DutyW-1:0] DUTY_FULL  = 8'd255;
    localparam logic [DutyW-1:0] RAMP_LOW   = 8'd1;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_SETTLE    = 4'd1,
        PH_RAMP      = 4'd2,
        PH_PAUSE     = 4'd3,
        PH_LOW_UP    = 4'd4,
        PH_LOW_DOWN  = 4'd5,
        PH_HIGH_DOWN = 4'd6,
        PH_HIGH_UP   = 4'd7,
        PH_RELEASE   = 4'd8
    } t_phase;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_SETTLE     = 3'd0,
        CFG_RAMP_STEP  = 3'd1,
        CFG_PAUSE      = 3'd2,
        CFG_LOW_PULSE  = 3'd3,
        CFG_HIGH_PULSE = 3'd4,
        CFG_RELEASE    = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [DutyW-1:0] settle_ms;
        logic [DutyW-1:0] ramp_step_ms;
        logic [DutyW-1:0] limit_pause_ms;
        logic [DutyW-1:0] low_pulse_step_ms;
        logic [DutyW-1:0] high_pulse_step_ms;
        logic [DutyW-1:0] release_wait_ms;
    } t_cfg;

    typedef struct packed {
        t_phase           phase;
        logic [DutyW-1:0] duty_level;
        logic             drive_enabled;
        logic             going_down;
        logic [DutyW-1:0] wait_count;
        logic [DutyW-1:0] pulse_level;
    } t_state;

    typedef struct packed {
        t_state st;
        logic   cont;
    } t_dec;

    // One decision of the dimmer sequence; cont asks for another in the same tick.
    function automatic t_dec sbd_decide(t_state s, logic held, t_cfg c);
        t_dec             d;
        logic [DutyW-1:0] p;
        d = '{st: s, cont: 1'b0};
        p = '0;
        unique case (s.phase)
            PH_SETTLE: begin
                d.st.pulse_level = s.duty_level;
                d.st.phase = PH_RAMP;
                d.cont = 1'b1;
            end
            PH_RAMP: begin
                if (held && (s.going_down ? (s.pulse_level != '0)
                                          : (s.pulse_level != DUTY_FULL))) begin
                    d.st.duty_level = s.pulse_level;
                    d.st.drive_enabled = 1'b1;
                    d.st.wait_count = c.ramp_step_ms;
                    d.st.pulse_level = s.going_down ? s.pulse_level - 8'd1
                                                    : s.pulse_level + 8'd1;
                end else begin
                    d.st.phase = PH_PAUSE;
                    d.st.wait_count = c.limit_pause_ms;
                end
            end
            PH_PAUSE: begin
                if (s.going_down && s.duty_level == RAMP_LOW) begin
                    d.st.phase = PH_LOW_DOWN;
                    d.st.pulse_level = LOW_START;
                    d.cont = 1'b1;
                end else if (!s.going_down && s.duty_level == RAMP_TOP) begin
                    d.st.phase = PH_HIGH_UP;
                    d.st.pulse_level = HIGH_START;
                    d.cont = 1'b1;
                end else begin
                    d.st.going_down = !s.going_down;
                    d.st.phase = PH_RELEASE;
                    d.st.wait_count = c.release_wait_ms;
                end
            end
            PH_LOW_UP: begin
                p = s.pulse_level + PULSE_STEP;
                if (p > LOW_PEAK) begin
                    p = LOW_PEAK;
                    d.st.phase = PH_LOW_DOWN;
                end
                d.st.pulse_level = p;
                d.st.duty_level = p;
                d.st.drive_enabled = 1'b1;
                d.st.wait_count = c.low_pulse_step_ms;
            end
            PH_LOW_DOWN: begin
                p = s.pulse_level - PULSE_STEP;
                d.st.pulse_level = p;
                if (p != '0) begin
                    d.st.duty_level = p;
                    d.st.drive_enabled = 1'b1;
                    d.st.wait_count = c.low_pulse_step_ms;
                end else if (held) begin
                    d.st.phase = PH_LOW_UP;
                    d.st.duty_level = '0;
                    d.st.drive_enabled = 1'b1;
                    d.st.wait_count = c.low_pulse_step_ms;
                end else begin
                    d.st.duty_level = '0;
                    d.st.drive_enabled = 1'b0;
                    d.st.going_down = 1'b0;
                    d.st.phase = PH_RELEASE;
                    d.st.wait_count = c.release_wait_ms;
                end
            end
            PH_HIGH_DOWN: begin
                p = s.pulse_level - PULSE_STEP;
                if (p <= HIGH_FLOOR) begin
                    p = HIGH_FLOOR;
                    d.st.phase = PH_HIGH_UP;
                end
                d.st.pulse_level = p;
                d.st.duty_level = p;
                d.st.drive_enabled = 1'b1;
                d.st.wait_count = c.high_pulse_step_ms;
            end
            PH_HIGH_UP: begin
                if (s.pulse_level < HIGH_START) begin
                    p = s.pulse_level + PULSE_STEP;
                    d.st.pulse_level = p;
                    d.st.duty_level = p;
                    d.st.drive_enabled = 1'b1;
                    d.st.wait_count = c.high_pulse_step_ms;
                end else if (held) begin
                    d.st.phase = PH_HIGH_DOWN;
                    d.st.pulse_level = DUTY_FULL;
                    d.st.duty_level = DUTY_FULL;
                    d.st.drive_enabled = 1'b1;
                    d.st.wait_count = c.high_pulse_step_ms;
                end else begin
                    d.st.duty_level = DUTY_FULL;
                    d.st.going_down = 1'b1;
                    d.st.phase = PH_RELEASE;
                    d.st.wait_count = c.release_wait_ms;
                end
            end
            PH_RELEASE: begin
                d.st.phase = PH_IDLE;
                d.cont = 1'b1;
            end
            default: begin
                d.st.phase = PH_IDLE;
                if (held) begin
                    d.st.phase = PH_SETTLE;
                    d.st.wait_count = c.settle_ms;
                end
            end
        endcase
        return d;
    endfunction

endpackage

>>> design/sbd_if.sv
interface sbd_in_if;
    logic valid;
    logic ready;
    logic button_held;

    modport source (output valid, output button_held, input ready);
    modport sink (input valid, input button_held, output ready);
endinterface

interface sbd_out_if;
    logic                    valid;
    logic                    ready;
    logic [sbd_pkg::DutyW-1:0] duty;
    logic                    drive_on;

    modport source (output valid, output duty, output drive_on, input ready);
    modport sink (input valid, input duty, input drive_on, output ready);
endinterface

interface sbd_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [sbd_pkg::CfgIdxW-1:0] index;
    logic [sbd_pkg::DutyW-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

>>> design/sbd_cfg_regs.sv
module sbd_cfg_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sbd_cfg_if.sink       i_cfg,
    output sbd_pkg::t_cfg o_cfg
);
    import sbd_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_SETTLE:     n_cfg.settle_ms = i_cfg.data;
                CFG_RAMP_STEP:  n_cfg.ramp_step_ms = i_cfg.data;
                CFG_PAUSE:      n_cfg.limit_pause_ms = i_cfg.data;
                CFG_LOW_PULSE:  n_cfg.low_pulse_step_ms = i_cfg.data;
                CFG_HIGH_PULSE: n_cfg.high_pulse_step_ms = i_cfg.data;
                CFG_RELEASE:    n_cfg.release_wait_ms = i_cfg.data;
                default:        n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{settle_ms: 8'd100, ramp_step_ms: 8'd5, limit_pause_ms: 8'd50,
                       low_pulse_step_ms: 8'd13, high_pulse_step_ms: 8'd10,
                       release_wait_ms: 8'd100};
        end else begin
            r_cfg <= n_cfg;
        end
    end
endmodule

>>> design/sbd_core.sv
module sbd_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  sbd_pkg::t_cfg             i_cfg,
    input  logic                      i_step,
    input  logic                      i_held,
    output logic [sbd_pkg::DutyW-1:0] o_duty,
    output logic                      o_drive_on
);
    import sbd_pkg::*;

    t_state r_state;
    t_state n_state;
    t_dec   dec_first;
    t_dec   dec_second;

    assign dec_first  = sbd_decide(r_state, i_held, i_cfg);
    assign dec_second = sbd_decide(dec_first.st, i_held, i_cfg);

    always_comb begin
        n_state = r_state;
        if (r_state.wait_count > 8'd1) begin
            n_state.wait_count = r_state.wait_count - 8'd1;
        end else if (dec_first.cont) begin
            n_state = dec_second.st;
        end else begin
            n_state = dec_first.st;
        end
    end

    assign o_duty     = n_state.duty_level;
    assign o_drive_on = n_state.drive_enabled;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{phase: PH_IDLE, duty_level: '0, drive_enabled: 1'b0,
                         going_down: 1'b0, wait_count: '0, pulse_level: '0};
        end else if (i_step) begin
            r_state <= n_state;
        end
    end
endmodule

>>> design/single_button_dimmer_ramp_unit.sv
// Single-button lamp dimmer, one request per millisecond tick.
// The input channel carries the button level of one tick. Every accepted
// request yields exactly one result request with the lamp duty and the
// drive enable that hold after that tick, in order.
// The configuration channel writes the six delay registers by index; it is
// always ready, and writes to indexes above five are dropped. It is meant to
// be used only while no request is in flight.
// A request is captured in an input register and passes through the dimmer
// sequencer into the result register once that register is empty or its
// result is taken. One request per cycle is sustained while the receiver takes
// results; the sequencer update is two chained decision steps of short logic.
// When the receiver stalls, the result register holds its request and the
// input register still takes one more request, after which input ready
// drops until the result is taken.
// Synchronous active-low reset returns the delay registers to their defaults,
// the sequencer to idle with the lamp off, and empties both registers.
module single_button_dimmer_ramp_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sbd_in_if.sink     i_in,
    sbd_out_if.source  o_out,
    sbd_cfg_if.sink    i_cfg
);
    import sbd_pkg::*;

    t_cfg             cfg;
    logic             r_in_vld;
    logic             r_in_held;
    logic             r_out_vld;
    logic [DutyW-1:0] r_duty;
    logic             r_drive;
    logic             step;
    logic [DutyW-1:0] n_duty;
    logic             n_drive;

    sbd_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    sbd_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_step     (step),
        .i_held     (r_in_held),
        .o_duty     (n_duty),
        .o_drive_on (n_drive)
    );

    assign step       = r_in_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready = !r_in_vld || step;

    assign o_out.valid    = r_out_vld;
    assign o_out.duty     = r_duty;
    assign o_out.drive_on = r_drive;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_in_vld <= 1'b1;
            end else if (step) begin
                r_in_vld <= 1'b0;
            end
            if (step) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_held <= i_in.button_held;
        end
        if (step) begin
            r_duty  <= n_duty;
            r_drive <= n_drive;
        end
    end
endmodule

>>> design/sbd_checker.sv
`include "single_button_dimmer_ramp_unit_macros.svh"

module sbd_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      i_in_ready,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic [sbd_pkg::DutyW-1:0] i_out_duty,
    input logic                      i_out_drive_on
);
    `SBD_ASSERT_RESET(a_reset_empty, !i_rst_n, !i_out_valid)
    `SBD_ASSERT_IMPL(a_off_means_dark, i_out_valid && !i_out_drive_on, i_out_duty == '0)
    `SBD_ASSERT_IMPL(a_block_only_full, !i_in_ready, i_out_valid && !i_out_ready)
    `SBD_ASSERT_NEXT(a_stall_holds, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_duty) && $stable(i_out_drive_on))
endmodule

bind single_button_dimmer_ramp_unit sbd_checker u_sbd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_duty     (o_out.duty),
    .i_out_drive_on (o_out.drive_on)
);

>>> tb/single_button_dimmer_ramp_unit_test.sv
`timescale 1ns / 100ps

module single_button_dimmer_ramp_unit_test;
    import sbd_pkg::*;

    localparam logic [DutyW-1:0] LAMP_FULL      = 8'd255;
    localparam logic [DutyW-1:0] RAMP_TOP_LVL   = 8'd254;
    localparam logic [DutyW-1:0] RAMP_BOTTOM    = 8'd1;
    localparam logic [DutyW-1:0] LOW_PEAK_LVL   = 8'd75;
    localparam logic [DutyW-1:0] HIGH_FLOOR_LVL = 8'd155;
    localparam logic [DutyW-1:0] HIGH_TOP_LVL   = 8'd250;
    localparam logic [DutyW-1:0] PULSE_INC      = 8'd5;
    localparam logic [DutyW-1:0] LONGEST_DELAY  = 8'd255;
    localparam logic [CfgIdxW-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CfgIdxW-1:0] CFG_SPARE_HI = 3'd7;
    localparam int unsigned REPORT_LIMIT     = 10;
    localparam int unsigned HOLD_OFF_CYCLES  = 60;
    localparam int unsigned DRAIN_PAUSE      = 4;
    localparam int unsigned END_SLACK        = 8;
    localparam int unsigned SETTING_COUNT    = 10;
    localparam int unsigned WIDE_BUDGET      = 380;
    localparam int unsigned NARROW_BUDGET    = 60;
    localparam int unsigned TIMEOUT_NS       = 15_000_000;

    typedef struct packed {
        logic [DutyW-1:0] duty;
        logic             drive_on;
    } t_lamp_out;

    class t_lamp_scoreboard;
        t_phase           phase;
        logic [DutyW-1:0] duty_level;
        logic [DutyW-1:0] wait_count;
        logic [DutyW-1:0] pulse_level;
        logic             drive_en;
        logic             going_down;
        logic [DutyW-1:0] delay_reg [6];
        t_lamp_out        lamp_expected [$];
        int unsigned      mismatches;
        int unsigned      checked;
        int unsigned      low_visits;
        int unsigned      high_visits;

        function new();
            phase = PH_IDLE;
            duty_level = '0;
            wait_count = '0;
            pulse_level = '0;
            drive_en = 1'b0;
            going_down = 1'b0;
            delay_reg[CFG_SETTLE] = 8'd100;
            delay_reg[CFG_RAMP_STEP] = 8'd5;
            delay_reg[CFG_PAUSE] = 8'd50;
            delay_reg[CFG_LOW_PULSE] = 8'd13;
            delay_reg[CFG_HIGH_PULSE] = 8'd10;
            delay_reg[CFG_RELEASE] = 8'd100;
            mismatches = 0;
            checked = 0;
            low_visits = 0;
            high_visits = 0;
        endfunction

        function void write_register(logic [CfgIdxW-1:0] idx, logic [DutyW-1:0] val);
            if (idx <= CFG_RELEASE) begin
                delay_reg[idx] = val;
            end
        endfunction

        function void drive_at(logic [DutyW-1:0] level, logic [DutyW-1:0] delay);
            duty_level = level;
            drive_en = 1'b1;
            wait_count = delay;
        endfunction

        function void enter_release();
            phase = PH_RELEASE;
            wait_count = delay_reg[CFG_RELEASE];
        endfunction

        // Returns 1 when another decision follows within the same tick.
        function bit decide(logic held);
            bit more;
            more = 1'b0;
            case (phase)
                PH_SETTLE: begin
                    pulse_level = duty_level;
                    phase = PH_RAMP;
                    more = 1'b1;
                end
                PH_RAMP: begin
                    if (held && (going_down ? (pulse_level != '0)
                                            : (pulse_level < LAMP_FULL))) begin
                        drive_at(pulse_level, delay_reg[CFG_RAMP_STEP]);
                        pulse_level = going_down ? pulse_level - 8'd1 : pulse_level + 8'd1;
                    end else begin
                        phase = PH_PAUSE;
                        wait_count = delay_reg[CFG_PAUSE];
                    end
                end
                PH_PAUSE: begin
                    if (going_down && duty_level == RAMP_BOTTOM) begin
                        phase = PH_LOW_DOWN;
                        pulse_level = PULSE_INC;
                        low_visits++;
                        more = 1'b1;
                    end else if (!going_down && duty_level == RAMP_TOP_LVL) begin
                        phase = PH_HIGH_UP;
                        pulse_level = HIGH_TOP_LVL;
                        high_visits++;
                        more = 1'b1;
                    end else begin
                        going_down = !going_down;
                        enter_release();
                    end
                end
                PH_LOW_UP: begin
                    pulse_level = pulse_level + PULSE_INC;
                    if (pulse_level > LOW_PEAK_LVL) begin
                        pulse_level = LOW_PEAK_LVL;
                        phase = PH_LOW_DOWN;
                    end
                    drive_at(pulse_level, delay_reg[CFG_LOW_PULSE]);
                end
                PH_LOW_DOWN: begin
                    pulse_level = pulse_level - PULSE_INC;
                    if (pulse_level != '0) begin
                        drive_at(pulse_level, delay_reg[CFG_LOW_PULSE]);
                    end else if (held) begin
                        phase = PH_LOW_UP;
                        drive_at('0, delay_reg[CFG_LOW_PULSE]);
                    end else begin
                        duty_level = '0;
                        drive_en = 1'b0;
                        going_down = 1'b0;
                        enter_release();
                    end
                end
                PH_HIGH_DOWN: begin
                    pulse_level = pulse_level - PULSE_INC;
                    if (pulse_level <= HIGH_FLOOR_LVL) begin
                        pulse_level = HIGH_FLOOR_LVL;
                        phase = PH_HIGH_UP;
                    end
                    drive_at(pulse_level, delay_reg[CFG_HIGH_PULSE]);
                end
                PH_HIGH_UP: begin
                    if (pulse_level < HIGH_TOP_LVL) begin
                        pulse_level = pulse_level + PULSE_INC;
                        drive_at(pulse_level, delay_reg[CFG_HIGH_PULSE]);
                    end else if (held) begin
                        phase = PH_HIGH_DOWN;
                        pulse_level = LAMP_FULL;
                        drive_at(LAMP_FULL, delay_reg[CFG_HIGH_PULSE]);
                    end else begin
                        duty_level = LAMP_FULL;
                        going_down = 1'b1;
                        enter_release();
                    end
                end
                PH_RELEASE: begin
                    phase = PH_IDLE;
                    more = 1'b1;
                end
                default: begin
                    phase = PH_IDLE;
                    if (held) begin
                        phase = PH_SETTLE;
                        wait_count = delay_reg[CFG_SETTLE];
                    end
                end
            endcase
            return more;
        endfunction

        function void log_tick(logic held);
            int guard;
            if (wait_count > 8'd1) begin
                wait_count = wait_count - 8'd1;
            end else begin
                wait_count = '0;
                guard = 0;
                while (guard < 8 && decide(held)) begin
                    guard++;
                end
            end
            lamp_expected.push_back('{duty: duty_level, drive_on: drive_en});
        endfunction

        function void note_failure(string msg);
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
                $display("%s", msg);
            end
        endfunction

        function void check_result(logic [DutyW-1:0] duty, logic drive_on);
            t_lamp_out want;
            if (lamp_expected.size() == 0) begin
                note_failure($sformatf("Unexpected lamp result: duty %0d drive %0b",
                                       duty, drive_on));
                return;
            end
            want = lamp_expected.pop_front();
            checked++;
            if (duty !== want.duty || drive_on !== want.drive_on) begin
                note_failure($sformatf(
                    "Lamp mismatch %0d: duty exp %0d got %0d, drive exp %0b got %0b",
                    checked, want.duty, duty, want.drive_on, drive_on));
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    sbd_in_if  in_bus ();
    sbd_out_if out_bus ();
    sbd_cfg_if cfg_bus ();

    t_lamp_scoreboard lamp_sb = new();

    logic [DutyW-1:0] delay_plan [6];
    int unsigned ticks_sent;
    int unsigned settings_used;
    int unsigned stall_left;
    int unsigned hold_off_left;
    bit          hold_off_pending;

    single_button_dimmer_ramp_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus),
        .i_cfg   (cfg_bus)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_bus.valid && in_bus.ready) begin
                lamp_sb.log_tick(in_bus.button_held);
            end
            if (out_bus.valid && out_bus.ready) begin
                lamp_sb.check_result(out_bus.duty, out_bus.drive_on);
            end
        end
    end

    initial begin
        int unsigned r;
        out_bus.ready = 1'b0;
        stall_left = 0;
        hold_off_left = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_off_left != 0) begin
                hold_off_left--;
                out_bus.ready = 1'b0;
            end else if (hold_off_pending) begin
                hold_off_pending = 1'b0;
                hold_off_left = HOLD_OFF_CYCLES;
                out_bus.ready = 1'b0;
            end else if (stall_left != 0) begin
                stall_left--;
                out_bus.ready = 1'b0;
            end else if ((lamp_sb.checked / 50) % 3 == 1) begin
                out_bus.ready = 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 3) begin
                    stall_left = $urandom_range(10, 40);
                    out_bus.ready = 1'b0;
                end else begin
                    out_bus.ready = (r < 75);
                end
            end
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("CHECK FAILED");
        $finish;
    end

    function automatic int unsigned ticks_of(logic [DutyW-1:0] v);
        return (v == '0) ? 1 : int'(v);
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        if ((ticks_sent / 64) % 3 == 0 || hold_off_pending || hold_off_left != 0) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    // Leaves valid high after acceptance; a gap before the next request or a drain lowers it.
    task automatic send_tick(input logic held);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            in_bus.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_bus.valid = 1'b1;
        in_bus.button_held = held;
        do @(posedge i_clk); while (!(in_bus.valid && in_bus.ready));
        ticks_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_run(input logic held, input int unsigned count);
        repeat (count) send_tick(held);
    endtask

    task automatic drain_results();
        in_bus.valid = 1'b0;
        while (lamp_sb.lamp_expected.size() != 0) @(posedge i_clk);
        repeat (DRAIN_PAUSE) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [DutyW-1:0] val);
        cfg_bus.valid = 1'b1;
        cfg_bus.index = idx;
        cfg_bus.data = val;
        do @(posedge i_clk); while (!cfg_bus.ready);
        lamp_sb.write_register(idx, val);
        @(negedge i_clk);
        cfg_bus.valid = 1'b0;
    endtask

    task automatic program_delays();
        for (int r = CFG_SETTLE; r <= CFG_RELEASE; r++) begin
            cfg_write(r[CfgIdxW-1:0], delay_plan[r]);
        end
        settings_used++;
    endtask

    task automatic run_setting(input int unsigned budget);
        int unsigned done;
        int unsigned len;
        int unsigned r;
        int unsigned pulse_ticks;
        done = 0;
        pulse_ticks = ticks_of(delay_plan[CFG_LOW_PULSE]);
        if (ticks_of(delay_plan[CFG_HIGH_PULSE]) > pulse_ticks) begin
            pulse_ticks = ticks_of(delay_plan[CFG_HIGH_PULSE]);
        end
        while (done < budget) begin
            r = $urandom_range(0, 99);
            if (r < 80) begin
                if (r < 55) begin
                    // Long enough to ramp all the way and run the limit pattern.
                    len = ticks_of(delay_plan[CFG_SETTLE])
                        + 257 * ticks_of(delay_plan[CFG_RAMP_STEP])
                        + ticks_of(delay_plan[CFG_PAUSE])
                        + $urandom_range(1, 40 * pulse_ticks);
                end else begin
                    len = $urandom_range(1, 40);
                end
                for (int i = 0; i < len && done < budget; i++) begin
                    send_tick(1'b1);
                    done++;
                end
            end else begin
                len = $urandom_range(1, 30);
                for (int i = 0; i < len && done < budget; i++) begin
                    send_tick(1'($urandom_range(0, 1)));
                    done++;
                end
            end
            if ($urandom_range(0, 99) < 60) begin
                len = ticks_of(delay_plan[CFG_RELEASE]) + $urandom_range(1, 8);
            end else begin
                len = $urandom_range(1, 6);
            end
            for (int i = 0; i < len && done < budget; i++) begin
                send_tick(1'b0);
                done++;
            end
        end
    endtask

    initial begin
        int unsigned narrow_idx;
        bit          wide;
        i_rst_n = 1'b0;
        in_bus.valid = 1'b0;
        in_bus.button_held = 1'b0;
        cfg_bus.valid = 1'b0;
        cfg_bus.index = '0;
        cfg_bus.data = '0;
        ticks_sent = 0;
        settings_used = 0;
        hold_off_pending = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset delays: a short press must not get past the settle wait.
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b0);
        drain_results();

        // Zero delays must behave as one tick; spare indexes are dropped.
        delay_plan[CFG_SETTLE] = 8'd0;
        delay_plan[CFG_RAMP_STEP] = 8'd1;
        delay_plan[CFG_PAUSE] = 8'd1;
        delay_plan[CFG_LOW_PULSE] = 8'd1;
        delay_plan[CFG_HIGH_PULSE] = 8'd1;
        delay_plan[CFG_RELEASE] = 8'd0;
        program_delays();
        cfg_write(CFG_SPARE_LO, 8'hFF);
        cfg_write(CFG_SPARE_HI, 8'h00);
        send_run(1'b1, 7);
        send_run(1'b0, 4);
        send_run(1'b1, 5);
        send_run(1'b0, 3);
        send_run(1'b1, 1);
        send_run(1'b0, 2);
        drain_results();

        narrow_idx = CFG_SETTLE;
        for (int s = 0; s < SETTING_COUNT; s++) begin
            wide = (s % 3 == 0);
            for (int r = CFG_SETTLE; r <= CFG_RELEASE; r++) begin
                if ($urandom_range(0, 9) == 0) begin
                    delay_plan[r] = 8'd0;
                end else if (wide && r == CFG_RAMP_STEP) begin
                    delay_plan[r] = 8'($urandom_range(1, 2));
                end else begin
                    delay_plan[r] = wide ? 8'($urandom_range(1, 4)) : 8'($urandom_range(1, 6));
                end
            end
            if (!wide) begin
                delay_plan[narrow_idx] = LONGEST_DELAY;
                narrow_idx++;
            end
            program_delays();
            if (s == 3) begin
                hold_off_pending = 1'b1;
            end
            run_setting(wide ? WIDE_BUDGET : NARROW_BUDGET);
            drain_results();
        end

        repeat (END_SLACK) @(posedge i_clk);
        $display("Sent %0d button ticks under %0d delay settings; %0d lamp results checked.",
                 ticks_sent, settings_used, lamp_sb.checked);
        $display("Low-end pattern entered %0d times, high-end pattern %0d times.",
                 lamp_sb.low_visits, lamp_sb.high_visits);
        if (lamp_sb.mismatches == 0 && lamp_sb.lamp_expected.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
